// ===== rtl/ssd_pkg.sv =====
// Shared types, constants and functions for the seven-segment scan driver.
// No dependencies; imported by every module of the block.
package ssd_pkg;

  localparam int unsigned DIGIT_COUNT = 4;
  localparam int unsigned PTR_W = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;
  localparam logic [PTR_W-1:0] LAST_DIGIT = PTR_W'(DIGIT_COUNT - 1);

  localparam int unsigned VALUE_W = 16;
  localparam int unsigned WORD_W = 16;

  localparam logic [7:0] BLANK_SEGMENTS = 8'hFF;

  // Operation codes carried by the operation field.
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // Reciprocal of ten for 16-bit operands: x / 10 == (x * 52429) >> 19.
  localparam logic [16:0] RECIP_TEN = 17'd52429;
  localparam int unsigned RECIP_SHIFT = 19;

  typedef enum logic {
    ST_IDLE,
    ST_LOAD
  } state_e;

  typedef struct packed {
    logic start_load;
    logic step;
    logic tick;
  } ssd_cmd_t;

  typedef struct packed {
    logic last_digit;
    logic out_busy;
  } ssd_status_t;

  // Active-low segment pattern of one decimal digit.
  function automatic logic [7:0] seg_code(input logic [3:0] digit);
    logic [7:0] code;
    case (digit)
      4'd0: code = 8'h03;
      4'd1: code = 8'h9F;
      4'd2: code = 8'h25;
      4'd3: code = 8'h0D;
      4'd4: code = 8'h99;
      4'd5: code = 8'h49;
      4'd6: code = 8'h41;
      4'd7: code = 8'h1F;
      4'd8: code = 8'h01;
      4'd9: code = 8'h09;
      default: code = BLANK_SEGMENTS;
    endcase
    return code;
  endfunction

  // Digit k drives bit (k + 4) mod 8 of the select byte.
  function automatic logic [7:0] select_byte(input logic [PTR_W-1:0] k);
    logic [2:0] sh;
    sh = 3'(k) + 3'd4;
    return 8'(8'd1 << sh);
  endfunction

endpackage

// ===== rtl/ssd_ctrl.sv =====
// Control state machine of the seven-segment scan driver.
// Depends on ssd_pkg; issues commands to ssd_datapath.
module ssd_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                operation_i,
  input  ssd_pkg::ssd_status_t status_i,
  output ssd_pkg::ssd_cmd_t    cmd_o
);
  import ssd_pkg::*;

  state_e state_q, state_d;
  logic   accept;

  assign accept = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept && operation_i == OP_LOAD) begin
          state_d = ST_LOAD;
        end
      end
      ST_LOAD: begin
        if (status_i.last_digit) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o       = 1'b0;
    cmd_o.start_load = 1'b0;
    cmd_o.step       = 1'b0;
    cmd_o.tick       = 1'b0;
    case (state_q)
      ST_IDLE: begin
        // A tick needs the output register free, or freed in this cycle.
        in_ready_o       = !status_i.out_busy;
        cmd_o.start_load = accept && operation_i == OP_LOAD;
        cmd_o.tick       = accept && operation_i == OP_TICK;
      end
      ST_LOAD: begin
        cmd_o.step = 1'b1;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

endmodule

// ===== rtl/ssd_datapath.sv =====
// Datapath of the seven-segment scan driver: digit extraction, segment
// store, scan pointer and output register. Depends on ssd_pkg.
module ssd_datapath (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  ssd_pkg::ssd_cmd_t           cmd_i,
  output ssd_pkg::ssd_status_t        status_o,
  input  logic [ssd_pkg::VALUE_W-1:0] value_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [ssd_pkg::WORD_W-1:0]  display_word_o
);
  import ssd_pkg::*;

  logic [VALUE_W-1:0] rest_q, rest_d;
  logic [PTR_W-1:0]   cnt_q, cnt_d;
  logic               done_q, done_d;
  logic [PTR_W-1:0]   ptr_q, ptr_d;
  logic [7:0]         seg_q [DIGIT_COUNT];
  logic [WORD_W-1:0]  word_q;
  logic               out_valid_q;

  logic [32:0]        prod;
  logic [13:0]        quot;
  logic [16:0]        quot_x10;
  logic [3:0]         digit;
  logic [7:0]         seg_next;

  // One division by ten per cycle through a reciprocal multiply.
  assign prod     = 33'(rest_q) * 33'(RECIP_TEN);
  assign quot     = prod[RECIP_SHIFT +: 14];
  assign quot_x10 = {quot, 3'b000} + {2'b00, quot, 1'b0};
  assign digit    = 4'(17'(rest_q) - quot_x10);
  assign seg_next = done_q ? BLANK_SEGMENTS : seg_code(digit);

  always_comb begin
    rest_d = rest_q;
    cnt_d  = cnt_q;
    done_d = done_q;
    if (cmd_i.start_load) begin
      rest_d = value_i;
      cnt_d  = '0;
      done_d = 1'b0;
    end else if (cmd_i.step) begin
      rest_d = VALUE_W'(quot);
      cnt_d  = (cnt_q == LAST_DIGIT) ? '0 : cnt_q + PTR_W'(1);
      if (quot == '0) begin
        done_d = 1'b1;
      end
    end
  end

  always_comb begin
    ptr_d = ptr_q;
    if (cmd_i.tick) begin
      ptr_d = (ptr_q == LAST_DIGIT) ? '0 : ptr_q + PTR_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    rest_q <= rest_d;
    if (cmd_i.tick) begin
      word_q <= {select_byte(ptr_q), seg_q[ptr_q]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      done_q      <= 1'b0;
      ptr_q       <= '0;
      out_valid_q <= 1'b0;
      for (int unsigned k = 0; k < DIGIT_COUNT; k++) begin
        seg_q[k] <= BLANK_SEGMENTS;
      end
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
      ptr_q  <= ptr_d;
      if (cmd_i.step) begin
        seg_q[cnt_q] <= seg_next;
      end
      if (cmd_i.tick) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign status_o.last_digit = (cnt_q == LAST_DIGIT);
  assign status_o.out_busy   = out_valid_q && !out_ready_i;
  assign out_valid_o         = out_valid_q;
  assign display_word_o      = word_q;

endmodule

// ===== rtl/seven_segment_scan_driver.sv =====
// Four-digit multiplexed seven-segment scan driver. A tick transfer queues
// one display word in the output register; a new item is taken while that
// word waits, as long as it is being taken in the same cycle or the register
// is empty. After a load transfer is accepted, the single divide-by-ten unit
// peels one decimal digit per cycle, one for each of the DIGIT_COUNT digits;
// no input is taken during that time. A load produces no output word.
// Depends on ssd_pkg, ssd_ctrl and ssd_datapath.
module seven_segment_scan_driver (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic                       operation_i,
  input  logic [ssd_pkg::VALUE_W-1:0] value_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [ssd_pkg::WORD_W-1:0]  display_word_o
);
  import ssd_pkg::*;

  ssd_cmd_t    cmd;
  ssd_status_t status;

  ssd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .operation_i (operation_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  ssd_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .value_i        (value_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .display_word_o (display_word_o)
  );

endmodule
